// ===== hdl/rres_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rres_pkg;

    // Slot status codes
    localparam logic [2:0] STAT_FREE         = 3'd0;
    localparam logic [2:0] STAT_DYING        = 3'd1;
    localparam logic [2:0] STAT_RUNNABLE     = 3'd2;
    localparam logic [2:0] STAT_RUNNING      = 3'd3;
    localparam logic [2:0] STAT_NOT_RUNNABLE = 3'd4;

    // Result outcome codes
    localparam logic [1:0] OUT_CHOSEN    = 2'd0;
    localparam logic [1:0] OUT_HALT_IDLE = 2'd1;
    localparam logic [1:0] OUT_NO_LIVE   = 2'd2;

    // Request modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_YIELD = 1'b1;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_CH_RD  = 7'b0001000,
        S_CH_WB  = 7'b0010000,
        S_CH_SET = 7'b0100000,
        S_HALT   = 7'b1000000
    } sched_state_t;

endpackage

`default_nettype wire

// ===== hdl/round_robin_env_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                          Direction
// s_        s_valid s_ready s_mode s_slot s_new_status      request in
// m_        m_valid m_ready m_outcome m_chosen_slot
//           m_pick_count m_yield_count                      result out
//
// A write request (mode 0) gives no result. In a yield request the status
// memory is read one slot per cycle in circular order, then, if a slot is
// picked, a read/write-back pass on the picked slot and the old current slot.
// After reset a clearing pass zeroes both memories, with s_ready low.
// A result waits in the output register; the next request is taken meanwhile,
// and a yield only stalls at its end if the previous result is still held.

module round_robin_env_scheduler #(
    parameter int SLOTS = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_mode,
    input  wire  [9:0]  s_slot,
    input  wire  [2:0]  s_new_status,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_outcome,
    output logic [9:0]  m_chosen_slot,
    output logic [31:0] m_pick_count,
    output logic [31:0] m_yield_count
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = (IW > 10) ? IW : 10;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [IW:0]   SLOTS_C  = (IW + 1)'(SLOTS);
    localparam logic [CW:0]   SLOTS_W  = (CW + 1)'(SLOTS);

    rres_pkg::sched_state_t state_reg, state_next;

    // status and pick memories
    logic [2:0]  status_mem [SLOTS];
    logic [31:0] picks_mem  [SLOTS];
    logic [2:0]  status_rd_reg;
    logic [31:0] picks_rd_reg;

    logic          st_re, st_we, pk_re, pk_we;
    logic [IW-1:0] st_ra, st_wa, pk_ra, pk_wa;
    logic [2:0]    st_wd;
    logic [31:0]   pk_wd;

    always_ff @(posedge aclk) begin
        if (st_we) begin
            status_mem[st_wa] <= st_wd;
        end
        if (st_re) begin
            status_rd_reg <= status_mem[st_ra];
        end
        if (pk_we) begin
            picks_mem[pk_wa] <= pk_wd;
        end
        if (pk_re) begin
            picks_rd_reg <= picks_mem[pk_ra];
        end
    end

    // control state
    logic [IW-1:0] clr_addr_reg, clr_addr_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic          cur_vld_reg, cur_vld_next;
    logic [31:0]   yields_reg, yields_next;
    logic [IW-1:0] scan_addr_reg, scan_addr_next;
    logic [IW:0]   issue_cnt_reg, issue_cnt_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_last_reg, rd_last_next;
    logic          live_reg, live_next;
    logic          cur_run_reg, cur_run_next;
    logic [IW-1:0] chosen_reg, chosen_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_outcome_reg, m_outcome_next;
    logic [9:0]  m_chosen_reg, m_chosen_next;
    logic [31:0] m_picks_reg, m_picks_next;
    logic [31:0] m_yields_reg, m_yields_next;

    logic          in_take, in_range, out_free;
    logic [CW-1:0] slot_w, chosen_w;

    assign s_ready       = (state_reg == rres_pkg::S_IDLE);
    assign in_take       = s_valid && s_ready;
    assign slot_w        = CW'(s_slot);
    assign in_range      = {1'b0, slot_w} < SLOTS_W;
    assign out_free      = !m_valid_reg || m_ready;
    assign chosen_w      = CW'(chosen_reg);

    assign m_valid       = m_valid_reg;
    assign m_outcome     = m_outcome_reg;
    assign m_chosen_slot = m_chosen_reg;
    assign m_pick_count  = m_picks_reg;
    assign m_yield_count = m_yields_reg;

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cur_next       = cur_reg;
        cur_vld_next   = cur_vld_reg;
        yields_next    = yields_reg;
        scan_addr_next = scan_addr_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        rd_last_next   = rd_last_reg;
        live_next      = live_reg;
        cur_run_next   = cur_run_reg;
        chosen_next    = chosen_reg;

        m_valid_next   = m_valid_reg && !m_ready;
        m_outcome_next = m_outcome_reg;
        m_chosen_next  = m_chosen_reg;
        m_picks_next   = m_picks_reg;
        m_yields_next  = m_yields_reg;

        st_re = 1'b0;
        st_ra = scan_addr_reg;
        st_we = 1'b0;
        st_wa = clr_addr_reg;
        st_wd = rres_pkg::STAT_FREE;
        pk_re = 1'b0;
        pk_ra = chosen_reg;
        pk_we = 1'b0;
        pk_wa = clr_addr_reg;
        pk_wd = '0;

        unique case (state_reg)
            rres_pkg::S_CLEAR: begin
                st_we = 1'b1;
                pk_we = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX) begin
                    state_next = rres_pkg::S_IDLE;
                end
            end
            rres_pkg::S_IDLE: begin
                if (in_take && s_mode == rres_pkg::MODE_WRITE) begin
                    st_we = in_range;
                    st_wa = slot_w[IW-1:0];
                    st_wd = s_new_status;
                end else if (in_take) begin
                    yields_next    = yields_reg + 32'd1;
                    issue_cnt_next = '0;
                    live_next      = 1'b0;
                    cur_run_next   = 1'b0;
                    if (!cur_vld_reg || cur_reg == LAST_IDX) begin
                        scan_addr_next = '0;
                    end else begin
                        scan_addr_next = cur_reg + 1'b1;
                    end
                    state_next = rres_pkg::S_SCAN;
                end
            end
            rres_pkg::S_SCAN: begin
                // issue one status read per cycle
                if (issue_cnt_reg < SLOTS_C) begin
                    st_re          = 1'b1;
                    rd_vld_next    = 1'b1;
                    rd_idx_next    = scan_addr_reg;
                    rd_last_next   = (issue_cnt_reg == SLOTS_C - 1'b1);
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    scan_addr_next = (scan_addr_reg == LAST_IDX) ? '0
                                                                 : scan_addr_reg + 1'b1;
                end
                // check the status read last cycle
                if (rd_vld_reg) begin
                    if (status_rd_reg == rres_pkg::STAT_RUNNABLE) begin
                        chosen_next = rd_idx_reg;
                        rd_vld_next = 1'b0;
                        state_next  = rres_pkg::S_CH_RD;
                    end else begin
                        if (status_rd_reg == rres_pkg::STAT_DYING ||
                            status_rd_reg == rres_pkg::STAT_RUNNING) begin
                            live_next = 1'b1;
                        end
                        if (cur_vld_reg && rd_idx_reg == cur_reg) begin
                            cur_run_next = (status_rd_reg == rres_pkg::STAT_RUNNING);
                        end
                        if (rd_last_reg) begin
                            rd_vld_next = 1'b0;
                            if (cur_vld_reg && cur_run_next) begin
                                chosen_next = cur_reg;
                                state_next  = rres_pkg::S_CH_RD;
                            end else begin
                                state_next = rres_pkg::S_HALT;
                            end
                        end
                    end
                end
            end
            rres_pkg::S_CH_RD: begin
                // old current status and picked slot's counter
                st_re      = 1'b1;
                st_ra      = cur_reg;
                pk_re      = 1'b1;
                state_next = rres_pkg::S_CH_WB;
            end
            rres_pkg::S_CH_WB: begin
                if (cur_vld_reg && status_rd_reg == rres_pkg::STAT_RUNNING) begin
                    st_we = 1'b1;
                    st_wa = cur_reg;
                    st_wd = rres_pkg::STAT_RUNNABLE;
                end
                state_next = rres_pkg::S_CH_SET;
            end
            rres_pkg::S_CH_SET: begin
                if (out_free) begin
                    st_we          = 1'b1;
                    st_wa          = chosen_reg;
                    st_wd          = rres_pkg::STAT_RUNNING;
                    pk_we          = 1'b1;
                    pk_wa          = chosen_reg;
                    pk_wd          = picks_rd_reg + 32'd1;
                    cur_next       = chosen_reg;
                    cur_vld_next   = 1'b1;
                    m_valid_next   = 1'b1;
                    m_outcome_next = rres_pkg::OUT_CHOSEN;
                    m_chosen_next  = chosen_w[9:0];
                    m_picks_next   = picks_rd_reg + 32'd1;
                    m_yields_next  = yields_reg;
                    state_next     = rres_pkg::S_IDLE;
                end
            end
            rres_pkg::S_HALT: begin
                if (out_free) begin
                    cur_next       = '0;
                    cur_vld_next   = 1'b0;
                    m_valid_next   = 1'b1;
                    m_outcome_next = live_reg ? rres_pkg::OUT_HALT_IDLE
                                              : rres_pkg::OUT_NO_LIVE;
                    m_chosen_next  = '0;
                    m_picks_next   = '0;
                    m_yields_next  = yields_reg;
                    state_next     = rres_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rres_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rres_pkg::S_CLEAR;
            clr_addr_reg <= '0;
            cur_reg      <= '0;
            cur_vld_reg  <= 1'b0;
            yields_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cur_reg      <= cur_next;
            cur_vld_reg  <= cur_vld_next;
            yields_reg   <= yields_next;
            rd_vld_reg   <= rd_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload and scan bookkeeping
    always_ff @(posedge aclk) begin
        scan_addr_reg <= scan_addr_next;
        issue_cnt_reg <= issue_cnt_next;
        rd_idx_reg    <= rd_idx_next;
        rd_last_reg   <= rd_last_next;
        live_reg      <= live_next;
        cur_run_reg   <= cur_run_next;
        chosen_reg    <= chosen_next;
        m_outcome_reg <= m_outcome_next;
        m_chosen_reg  <= m_chosen_next;
        m_picks_reg   <= m_picks_next;
        m_yields_reg  <= m_yields_next;
    end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS          = 1024;
    localparam int TOTAL_REQUESTS = 580;
    // The limit leaves ample margin over the longest correct run (every request
    // a full-table yield, plus the clearing pass).
    localparam int CYCLE_LIMIT    = 3_000_000;
    // One yield walks the whole table, so this covers a stray late result.
    localparam int DRAIN_CYCLES   = SLOTS + 64;
    localparam int HOLD_CYCLES    = 4500;

    // Status codes 5..7 have no meaning but are stored as written.
    localparam logic [2:0] STAT_UNDEF_LO = 3'd5;
    localparam logic [2:0] STAT_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [9:0]  slot;
        logic [31:0] picks;
        logic [31:0] yields;
    } sched_result_t;

    // Predictor plus ordered store of expected yield results.
    class sched_scoreboard;
        logic [2:0]    slot_state [SLOTS];
        logic [31:0]   slot_picks [SLOTS];
        logic [9:0]    cur_slot;
        bit            cur_valid;
        logic [31:0]   yield_total;
        sched_result_t expected_q [$];
        int            errors;
        int            writes;
        int            yields;
        int            n_chosen;
        int            n_halt;
        int            n_no_live;

        function new();
            foreach (slot_state[i]) begin
                slot_state[i] = rres_pkg::STAT_FREE;
                slot_picks[i] = '0;
            end
            cur_slot    = '0;
            cur_valid   = 1'b0;
            yield_total = '0;
            errors      = 0;
            writes      = 0;
            yields      = 0;
            n_chosen    = 0;
            n_halt      = 0;
            n_no_live   = 0;
        endfunction

        function bit is_live(logic [2:0] st);
            return st == rres_pkg::STAT_DYING || st == rres_pkg::STAT_RUNNABLE ||
                   st == rres_pkg::STAT_RUNNING;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        // Old current slot drops back to runnable, the picked one starts running.
        function void run_slot(int unsigned idx);
            sched_result_t res;
            if (cur_valid && slot_state[cur_slot] == rres_pkg::STAT_RUNNING)
                slot_state[cur_slot] = rres_pkg::STAT_RUNNABLE;
            cur_slot        = idx[9:0];
            cur_valid       = 1'b1;
            slot_state[idx] = rres_pkg::STAT_RUNNING;
            slot_picks[idx] = slot_picks[idx] + 1;
            res.outcome     = rres_pkg::OUT_CHOSEN;
            res.slot        = idx[9:0];
            res.picks       = slot_picks[idx];
            res.yields      = yield_total;
            expected_q.push_back(res);
            n_chosen++;
        endfunction

        function void note_request(logic mode, logic [9:0] slot, logic [2:0] status);
            int unsigned   start;
            int unsigned   idx;
            bit            live;
            sched_result_t res;
            if (mode == rres_pkg::MODE_WRITE) begin
                slot_state[slot] = status;
                writes++;
                return;
            end
            yields++;
            yield_total = yield_total + 1;
            start = cur_valid ? (int'(cur_slot) + 1) % SLOTS : 0;
            for (int i = 0; i < SLOTS; i++) begin
                idx = (start + i) % SLOTS;
                if (slot_state[idx] == rres_pkg::STAT_RUNNABLE) begin
                    run_slot(idx);
                    return;
                end
            end
            // nothing runnable: keep the current slot if it is still running
            if (cur_valid && slot_state[cur_slot] == rres_pkg::STAT_RUNNING) begin
                run_slot(cur_slot);
                return;
            end
            live = 1'b0;
            foreach (slot_state[i])
                if (is_live(slot_state[i]))
                    live = 1'b1;
            cur_valid   = 1'b0;
            cur_slot    = '0;
            res.outcome = live ? rres_pkg::OUT_HALT_IDLE : rres_pkg::OUT_NO_LIVE;
            res.slot    = '0;
            res.picks   = '0;
            res.yields  = yield_total;
            expected_q.push_back(res);
            if (live)
                n_halt++;
            else
                n_no_live++;
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                flag($sformatf("%s: expected %0d, got %0d", name, want, got));
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (expected_q.size() == 0) begin
                flag($sformatf("result with none pending: outcome %0d slot %0d picks %0d yields %0d",
                               got.outcome, got.slot, got.picks, got.yields));
                return;
            end
            want = expected_q.pop_front();
            check_field("outcome", 32'(want.outcome), 32'(got.outcome));
            check_field("chosen_slot", 32'(want.slot), 32'(got.slot));
            check_field("pick_count", want.picks, got.picks);
            check_field("yield_count", want.yields, got.yields);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = rres_pkg::MODE_WRITE;
    logic [9:0]  s_slot = '0;
    logic [2:0]  s_new_status = rres_pkg::STAT_FREE;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_outcome;
    logic [9:0]  m_chosen_slot;
    logic [31:0] m_pick_count;
    logic [31:0] m_yield_count;

    sched_scoreboard sb;

    // Idle percentages per side, changed by the stimulus between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Long receiver hold-off: stimulus bumps hold_req, receiver acks it.
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int cycle_count = 0;

    logic [9:0] pool [8];

    always #5 aclk = ~aclk;

    round_robin_env_scheduler #(.SLOTS(SLOTS)) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_slot        (s_slot),
        .s_new_status  (s_new_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_outcome     (m_outcome),
        .m_chosen_slot (m_chosen_slot),
        .m_pick_count  (m_pick_count),
        .m_yield_count (m_yield_count)
    );

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a lost result ends here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still pending",
                 cycle_count, sb.expected_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random back-pressure, plus the long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Result monitor: values are sampled as they stood at the edge.
    always @(posedge aclk) begin
        sched_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.outcome = m_outcome;
            got.slot    = m_chosen_slot;
            got.picks   = m_pick_count;
            got.yields  = m_yield_count;
            sb.check_result(got);
        end
    end

    // Offer one request; valid stays up across back-to-back requests and only
    // drops when the sender decides to idle. Returns at the accepting edge.
    task automatic send_request(input logic mode, input logic [9:0] slot,
                                input logic [2:0] status);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_slot       <= slot;
        s_new_status <= status;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_request(mode, slot, status);
    endtask

    task automatic write_status(input logic [9:0] slot, input logic [2:0] status);
        send_request(rres_pkg::MODE_WRITE, slot, status);
    endtask

    // Yield request; slot and status fields carry junk the block must ignore.
    task automatic yield_request();
        send_request(rres_pkg::MODE_YIELD, 10'($urandom_range(0, 1023)),
                     3'($urandom_range(0, 7)));
    endtask

    // Return every live slot to free so halts and empty tables show up again.
    task automatic free_live_slots();
        for (int i = 0; i < SLOTS; i++)
            if (sb.is_live(sb.slot_state[i]))
                write_status(10'(i), rres_pkg::STAT_FREE);
    endtask

    task automatic random_request();
        int          r;
        logic [2:0]  st;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            free_live_slots();
        end else if (r < 38) begin
            yield_request();
        end else if (r < 80) begin
            // a small pool of slots carries the scheduling activity
            if ($urandom_range(0, 9) == 0)
                st = 3'($urandom_range(STAT_UNDEF_LO, STAT_UNDEF_HI));
            else
                st = 3'($urandom_range(rres_pkg::STAT_FREE, rres_pkg::STAT_NOT_RUNNABLE));
            write_status(pool[$urandom_range(0, 7)], st);
        end else begin
            // anywhere in the table, mostly codes that never get scheduled
            if ($urandom_range(0, 9) == 0) begin
                st = 3'($urandom_range(0, 7));
            end else begin
                case ($urandom_range(0, 2))
                    0:       st = rres_pkg::STAT_FREE;
                    1:       st = rres_pkg::STAT_NOT_RUNNABLE;
                    default: st = 3'($urandom_range(STAT_UNDEF_LO, STAT_UNDEF_HI));
                endcase
            end
            write_status(10'($urandom_range(0, 1023)), st);
        end
    endtask

    initial begin
        bit pressed;
        int sent;
        sb = new();
        pool[0] = 10'd0;
        pool[1] = 10'd1023;
        pool[2] = 10'd1;
        pool[3] = 10'd2;
        pool[4] = 10'd511;
        pool[5] = 10'd512;
        pool[6] = 10'($urandom_range(3, 510));
        pool[7] = 10'($urandom_range(513, 1022));
        pressed = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase one: sender idles about a third of the time, receiver most.
        send_idle_pct = 32;
        recv_idle_pct = 63;

        // Empty table: halt with no live slots.
        yield_request();
        // Top slot found from a scan that starts at zero.
        write_status(10'd1023, rres_pkg::STAT_RUNNABLE);
        yield_request();
        // Nothing else runnable, so the running current slot is kept.
        yield_request();
        // Scan past the top slot wraps to slot zero.
        write_status(10'd0, rres_pkg::STAT_RUNNABLE);
        yield_request();
        yield_request();
        // Current slot no longer running: not demoted, not kept.
        write_status(10'd1023, rres_pkg::STAT_NOT_RUNNABLE);
        yield_request();
        // Only a dying slot left: halt while something is still live.
        write_status(10'd0, rres_pkg::STAT_DYING);
        yield_request();
        yield_request();
        // Undefined codes are neither runnable nor live.
        write_status(10'd0, STAT_UNDEF_HI);
        write_status(10'd1023, STAT_UNDEF_LO);
        write_status(10'd512, STAT_UNDEF_LO + 3'd1);
        yield_request();
        // Alternating slot bits; a running slot that is not current is skipped.
        write_status(10'd682, rres_pkg::STAT_RUNNABLE);
        write_status(10'd341, rres_pkg::STAT_RUNNING);
        yield_request();
        yield_request();
        write_status(10'd682, rres_pkg::STAT_FREE);
        yield_request();
        write_status(10'd341, rres_pkg::STAT_FREE);
        yield_request();

        // Random part, three back-pressure phases by request count.
        sent = sb.writes + sb.yields;
        while (sent < TOTAL_REQUESTS) begin
            if (sent < TOTAL_REQUESTS / 3) begin
                send_idle_pct = 32;
                recv_idle_pct = 63;
            end else if (sent < 2 * TOTAL_REQUESTS / 3) begin
                send_idle_pct = 63;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (!pressed) begin
                    // Hold results off while yields keep coming, so the output
                    // register stays full and the block stalls its input.
                    pressed = 1'b1;
                    write_status(pool[2], rres_pkg::STAT_RUNNABLE);
                    write_status(pool[5], rres_pkg::STAT_RUNNABLE);
                    hold_req = hold_req + 1;
                    repeat (5) yield_request();
                end
            end
            random_request();
            sent = sb.writes + sb.yields;
        end
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.expected_q.size() != 0)
            sb.flag($sformatf("%0d expected results never arrived", sb.expected_q.size()));

        $display("Run covered %0d requests: %0d yields and %0d status writes",
                 sb.writes + sb.yields, sb.yields, sb.writes);
        $display("Yield outcomes: %0d picks, %0d halts with live slots, %0d with none",
                 sb.n_chosen, sb.n_halt, sb.n_no_live);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rres_pkg.sv
hdl/round_robin_env_scheduler.sv
sim/tb_top.sv
